>>> rtl/core/first_fit_region_allocator_top_defines.svh
`ifndef FIRST_FIT_REGION_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FFRA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("ffra check failed");

// Next-cycle implication, checked out of reset.
`define FFRA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("ffra check failed");

`endif

>>> rtl/core/ffra_pkg.sv
`timescale 1ns / 1ps

package ffra_pkg;

  // Descriptor table geometry.
  localparam int SLOT_COUNT = 64;
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int MOVE_W = $clog2(SLOT_COUNT + 2);

  // Sizes are kept in units aligned to 16 bytes.
  localparam logic [31:0] ALIGN_MASK = 32'h0000_000F;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_OVER_LIMIT = 2'd3
  } status_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_REGION_START = 2'd0;
  localparam logic [1:0] CFG_REGION_END   = 2'd1;
  localparam logic [1:0] CFG_ACTIVE_SLOTS = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic rel_read;
    logic chk;
    logic move;
    logic finish_alloc;
    logic finish_rel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_release;
    logic scan_done;
    logic hit;
    logic move_fail;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/core/ffra_ctrl.sv
`timescale 1ns / 1ps
`include "first_fit_region_allocator_top_defines.svh"

module ffra_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ffra_pkg::dp_sts_t sts,
  output ffra_pkg::dp_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_REL_RD   = 7'b0000010,
    S_REL_DONE = 7'b0000100,
    S_SCAN_RD  = 7'b0001000,
    S_SCAN_CHK = 7'b0010000,
    S_MOVE     = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = sts.req_release ? S_REL_RD : S_SCAN_RD;
        end
      end
      S_REL_RD: begin
        cmd.rel_read = 1'b1;
        state_next   = S_REL_DONE;
      end
      S_REL_DONE: begin
        cmd.rel_read = 1'b1;
        if (sts.out_free) begin
          cmd.finish_rel = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        state_next = sts.scan_done ? S_FINISH : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.chk    = 1'b1;
        state_next = sts.hit ? S_MOVE : S_SCAN_RD;
      end
      S_MOVE: begin
        cmd.move   = 1'b1;
        state_next = sts.move_fail ? S_FINISH : S_SCAN_RD;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish_alloc = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A result is only committed when the output register can take it.
  `FFRA_ASSERT_IMP(a_commit_needs_room, clk, rst,
                   cmd.finish_alloc || cmd.finish_rel, sts.out_free)
  // At most one of start, check, move and the two commits is issued in a cycle.
  `FFRA_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1,
                   $onehot0({cmd.start, cmd.chk, cmd.move, cmd.finish_alloc, cmd.finish_rel}))
  // A release item reads its slot in the cycle after it is taken.
  `FFRA_ASSERT_NXT(a_release_reads, clk, rst, cmd.start && sts.req_release, cmd.rel_read)

endmodule

>>> rtl/core/ffra_dp.sv
`timescale 1ns / 1ps
`include "first_fit_region_allocator_top_defines.svh"

module ffra_dp (
  input  logic              clk,
  input  logic              rst,
  input  ffra_pkg::dp_cmd_t cmd,
  output ffra_pkg::dp_sts_t sts,
  input  logic              req_type,
  input  logic [30:0]       request_bytes,
  input  logic [5:0]        release_slot,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       block_address,
  output logic [5:0]        granted_slot,
  output logic [1:0]        status,
  output logic [31:0]       bytes_used
);

  localparam int IDX_W  = ffra_pkg::IDX_W;
  localparam int CNT_W  = ffra_pkg::CNT_W;
  localparam int MOVE_W = ffra_pkg::MOVE_W;

  // Configuration registers.
  logic [31:0] region_start;
  logic [31:0] region_end;
  logic [6:0]  active_slots;

  // Search state for the item in progress.
  logic [31:0]       cand;
  logic [32:0]       cand_end;
  logic [31:0]       size;
  logic [5:0]        rel_slot;
  logic              fail_q;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [CNT_W-1:0]  idx;
  logic [MOVE_W-1:0] moves;
  logic [32:0]       hit_fin;
  logic [31:0]       total;

  // Descriptor table.
  logic [31:0]           base_mem [ffra_pkg::SLOT_COUNT];
  logic [31:0]           len_mem  [ffra_pkg::SLOT_COUNT];
  logic [ffra_pkg::SLOT_COUNT-1:0] len_valid;
  logic [31:0]           rd_base;
  logic [31:0]           rd_len;
  logic                  rd_valid;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      rel_idx;

  logic [CNT_W-1:0] scan_n;
  logic [31:0]      size_in;
  logic             used;
  logic [32:0]      fin;
  logic             hit;
  logic [33:0]      move_sum;
  logic             move_fail;
  logic             rel_in_range;
  logic             rel_used;
  logic             mem_we;
  logic             rel_clear;
  logic             out_load;
  logic [31:0]      res_addr;
  logic [5:0]       res_slot;
  ffra_pkg::status_t res_status;
  logic [31:0]      total_next;

  assign cfg_ready = 1'b1;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_end   <= '0;
      active_slots <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        ffra_pkg::CFG_REGION_START: region_start <= cfg_data;
        ffra_pkg::CFG_REGION_END:   region_end   <= cfg_data;
        ffra_pkg::CFG_ACTIVE_SLOTS: active_slots <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Scan width and rounded request size.
  assign scan_n = (32'(active_slots) < 32'(ffra_pkg::SLOT_COUNT)) ?
                  CNT_W'(active_slots) : CNT_W'(ffra_pkg::SLOT_COUNT);
  assign size_in = (32'(request_bytes) + ffra_pkg::ALIGN_MASK) & ~ffra_pkg::ALIGN_MASK;

  assign rel_idx      = IDX_W'(rel_slot);
  assign rel_in_range = 32'(rel_slot) < 32'(ffra_pkg::SLOT_COUNT);
  assign rd_addr      = cmd.rel_read ? rel_idx : idx[IDX_W-1:0];

  // Overlap test of the slot just read against the candidate range.
  assign used = rd_valid && (rd_len != '0);
  assign fin  = {1'b0, rd_base} + {1'b0, rd_len};
  assign hit  = used && ((cand == rd_base) ||
                         ((rd_base < cand) && ({1'b0, cand} < fin)) ||
                         ((rd_base > cand) && ({1'b0, rd_base} < cand_end)));

  // A move fails if the moved block would reach the limit, or on too many moves.
  assign move_sum  = {1'b0, hit_fin} + {2'b00, size};
  assign move_fail = (move_sum >= {2'b00, region_end}) ||
                     (32'(moves) + 32'd1 > 32'(ffra_pkg::SLOT_COUNT));

  assign rel_used  = rel_in_range && used;
  assign mem_we    = cmd.finish_alloc && !fail_q && free_found;
  assign rel_clear = cmd.finish_rel && rel_used;
  assign out_load  = cmd.finish_alloc || cmd.finish_rel;

  // Search registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      size       <= size_in;
      cand       <= region_start;
      cand_end   <= {1'b0, region_start} + {1'b0, size_in};
      rel_slot   <= release_slot;
      moves      <= '0;
      idx        <= '0;
      free_found <= 1'b0;
      fail_q     <= 1'b0;
    end else if (cmd.chk) begin
      if (hit) begin
        hit_fin <= fin;
      end else begin
        idx <= idx + CNT_W'(1);
        if (!used && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= idx[IDX_W-1:0];
        end
      end
    end else if (cmd.move) begin
      moves <= moves + MOVE_W'(1);
      cand  <= hit_fin[31:0];
      if (move_fail) begin
        fail_q <= 1'b1;
      end else begin
        cand_end   <= move_sum[32:0];
        idx        <= '0;
        free_found <= 1'b0;
      end
    end
  end

  // Table storage with registered reads.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      base_mem[free_idx] <= cand;
      len_mem[free_idx]  <= size;
    end
    rd_base  <= base_mem[rd_addr];
    rd_len   <= len_mem[rd_addr];
    rd_valid <= len_valid[rd_addr];
  end

  // Per-slot valid bits; a slot never written reads as free.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_valid <= '0;
    end else if (mem_we) begin
      len_valid[free_idx] <= 1'b1;
    end else if (rel_clear) begin
      len_valid[rel_idx] <= 1'b0;
    end
  end

  // Result assembly for the finishing item.
  always_comb begin
    res_addr   = cand;
    res_slot   = '0;
    res_status = ffra_pkg::ST_OK;
    total_next = total;
    if (cmd.finish_rel) begin
      res_slot = rel_slot;
      res_addr = rel_used ? rd_base : '0;
      if (rel_used) begin
        total_next = total - rd_len;
      end
    end else if (fail_q) begin
      res_status = ffra_pkg::ST_NO_SPACE;
    end else if (!free_found) begin
      res_status = ffra_pkg::ST_TABLE_FULL;
    end else begin
      res_slot   = 6'(free_idx);
      total_next = total + size;
      if (cand_end >= {1'b0, region_end}) begin
        res_status = ffra_pkg::ST_OVER_LIMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (out_load) begin
      total <= total_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      block_address <= res_addr;
      granted_slot  <= res_slot;
      status        <= res_status;
      bytes_used    <= total_next;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.req_release = req_type;
    sts.scan_done   = (idx == scan_n);
    sts.hit         = hit;
    sts.move_fail   = move_fail;
    sts.out_free    = !out_valid || out_ready;
  end

  // A successful move restarts the scan and counts one move.
  `FFRA_ASSERT_NXT(a_move_restart, clk, rst, cmd.move && !move_fail,
                   (idx == '0) && (moves == $past(moves) + MOVE_W'(1)))
  // A slot with no overlap advances the scan by one.
  `FFRA_ASSERT_NXT(a_scan_step, clk, rst, cmd.chk && !hit,
                   idx == $past(idx) + CNT_W'(1))
  // A placed block adds its size to the running total.
  `FFRA_ASSERT_NXT(a_total_grows, clk, rst, mem_we,
                   total == 32'($past(total) + $past(size)))

endmodule

>>> rtl/core/first_fit_region_allocator_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    req_type, request_bytes, release_slot
// out      output     out_valid / out_ready  block_address, granted_slot, status, bytes_used
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time. A release reads its slot, then commits its result once the output
// register is free. An allocation reads and then checks each of n = min(active_slots, 64)
// slots in turn, since the table has a single read port; each move restarts the scan
// from slot 0. The scan ends early when a move fails.
// Reset clears the slot valid bits, the running total, the output valid flag, the configuration and the state.
// A waiting result does not stop the next item being taken; it holds that item's commit.

module first_fit_region_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [30:0] request_bytes,
  input  logic [5:0]  release_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] block_address,
  output logic [5:0]  granted_slot,
  output logic [1:0]  status,
  output logic [31:0] bytes_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ffra_pkg::dp_cmd_t cmd;
  ffra_pkg::dp_sts_t sts;

  // Sequencer.
  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, search registers and result register.
  ffra_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req_type),
    .request_bytes (request_bytes),
    .release_slot  (release_slot),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .block_address (block_address),
    .granted_slot  (granted_slot),
    .status        (status),
    .bytes_used    (bytes_used)
  );

endmodule
